>>> hw/rtl/v3alu_pkg.sv
// shared types and constants for the three-component vector unit
package v3alu_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OP_BITS       = 3;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_MAG   = 3'd5,
    OP_NORM  = 3'd6
  } op_t;

endpackage

>>> hw/rtl/v3alu_front.sv
// front pipeline: products, sums and saturation for the non-iterative operations
module v3alu_front #(
  parameter int WORD_BITS = v3alu_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  v3alu_pkg::op_t                op_i,
  input  logic signed [WORD_BITS-1:0]   a_i [3],
  input  logic signed [WORD_BITS-1:0]   b_i [3],
  input  logic signed [WORD_BITS-1:0]   s_i,
  output v3alu_pkg::op_t                op_o,
  output logic [WORD_BITS-1:0]          res_o [3],
  output logic [WORD_BITS-1:0]          scal_o,
  output logic                          ov_o,
  output logic [2*WORD_BITS-1:0]        sumsq_o,
  output logic signed [WORD_BITS-1:0]   a_o [3]
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;
  localparam int XW = 2 * WORD_BITS + 2;

  function automatic logic [W:0] sat_w(logic signed [XW-1:0] x);
    logic fits;
    fits = (&x[XW-1:W-1]) | ~(|x[XW-1:W-1]);
    if (fits) begin
      sat_w = {1'b0, x[W-1:0]};
    end else if (x[XW-1]) begin
      sat_w = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      sat_w = {1'b1, 1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // stage 1: multiplier operand select
  logic signed [W-1:0]  ma [6];
  logic signed [W-1:0]  mb [6];

  v3alu_pkg::op_t       op1_r;
  logic signed [PW-1:0] p1_r [6];
  logic signed [W:0]    as1_r [3];
  logic signed [W-1:0]  a1_r [3];

  always_comb begin
    ma[0] = a_i[0]; mb[0] = b_i[0];
    ma[1] = a_i[1]; mb[1] = b_i[1];
    ma[2] = a_i[2]; mb[2] = b_i[2];
    ma[3] = a_i[2]; mb[3] = b_i[1];
    ma[4] = a_i[0]; mb[4] = b_i[2];
    ma[5] = a_i[1]; mb[5] = b_i[0];
    unique case (op_i)
      v3alu_pkg::OP_SCALE: begin
        mb[0] = s_i; mb[1] = s_i; mb[2] = s_i;
      end
      v3alu_pkg::OP_MAG, v3alu_pkg::OP_NORM: begin
        mb[0] = a_i[0]; mb[1] = a_i[1]; mb[2] = a_i[2];
      end
      v3alu_pkg::OP_CROSS: begin
        ma[0] = a_i[1]; mb[0] = b_i[2];
        ma[1] = a_i[2]; mb[1] = b_i[0];
        ma[2] = a_i[0]; mb[2] = b_i[1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= op_i;
      for (int k = 0; k < 6; k++) begin
        p1_r[k] <= PW'(ma[k]) * PW'(mb[k]);
      end
      for (int i = 0; i < 3; i++) begin
        a1_r[i] <= a_i[i];
        if (op_i == v3alu_pkg::OP_SUB) begin
          as1_r[i] <= (W+1)'(a_i[i]) - (W+1)'(b_i[i]);
        end else begin
          as1_r[i] <= (W+1)'(a_i[i]) + (W+1)'(b_i[i]);
        end
      end
    end
  end

  // stage 2: combine and scale down
  logic signed [XW-1:0] px [6];
  logic signed [XW-1:0] v_nxt [3];
  logic signed [XW-1:0] sc_nxt;
  logic signed [XW-1:0] sum3;

  v3alu_pkg::op_t       op2_r;
  logic signed [XW-1:0] v2_r [3];
  logic signed [XW-1:0] sc2_r;
  logic [PW-1:0]        ss2_r;
  logic signed [W-1:0]  a2_r [3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      px[k] = XW'(p1_r[k]);
    end
    sum3   = px[0] + px[1] + px[2];
    sc_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      v_nxt[i] = '0;
    end
    unique case (op1_r)
      v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          v_nxt[i] = XW'(as1_r[i]);
        end
      end
      v3alu_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          v_nxt[i] = px[i] >>> FRAC_BITS;
        end
      end
      v3alu_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          v_nxt[i] = (px[i] - px[i+3]) >>> FRAC_BITS;
        end
      end
      v3alu_pkg::OP_DOT: begin
        sc_nxt = sum3 >>> FRAC_BITS;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r <= op1_r;
      sc2_r <= sc_nxt;
      ss2_r <= PW'(sum3);
      for (int i = 0; i < 3; i++) begin
        v2_r[i] <= v_nxt[i];
        a2_r[i] <= a1_r[i];
      end
    end
  end

  // stage 3: saturate to the word
  logic [W:0] sv [3];
  logic [W:0] ssc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i] = sat_w(v2_r[i]);
    end
    ssc = sat_w(sc2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_o    <= op2_r;
      scal_o  <= ssc[W-1:0];
      ov_o    <= sv[0][W] | sv[1][W] | sv[2][W] | ssc[W];
      sumsq_o <= ss2_r;
      for (int i = 0; i < 3; i++) begin
        res_o[i] <= sv[i][W-1:0];
        a_o[i]   <= a2_r[i];
      end
    end
  end

endmodule

>>> hw/rtl/v3alu_sqrt.sv
// pipelined integer square root, one result bit per stage, with a carried tag
module v3alu_sqrt #(
  parameter int WORD_BITS = v3alu_pkg::WORD_BITS_DEF,
  parameter int TAG_BITS  = 1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2*WORD_BITS-1:0] x_i,
  input  logic [TAG_BITS-1:0]    tag_i,
  output logic [WORD_BITS-1:0]   root_o,
  output logic [TAG_BITS-1:0]    tag_o
);

  localparam int W = WORD_BITS;

  logic [W-1:0]        rem_r  [W];
  logic [W-1:0]        root_r [W];
  logic [2*W-1:0]      x_r    [W];
  logic [TAG_BITS-1:0] tag_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]        rem_p;
    logic [W-1:0]        root_p;
    logic [2*W-1:0]      x_p;
    logic [TAG_BITS-1:0] tag_p;
    logic [W+1:0]        rem_sh;
    logic [W+1:0]        trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x_i;
      assign tag_p  = tag_i;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign x_p    = x_r[k-1];
      assign tag_p  = tag_r[k-1];
    end

    assign rem_sh = {rem_p, x_p[2*W-1:2*W-2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? W'(rem_sh - trial) : W'(rem_sh);
        root_r[k] <= {root_p[W-2:0], ge};
        x_r[k]    <= x_p << 2;
        tag_r[k]  <= tag_p;
      end
    end
  end

  assign root_o = root_r[W-1];
  assign tag_o  = tag_r[W-1];

endmodule

>>> hw/rtl/v3alu_div.sv
// pipelined restoring divider for normalize, one quotient bit per stage
module v3alu_div #(
  parameter int WORD_BITS = v3alu_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] num_i,
  input  logic [WORD_BITS-1:0] den_i,
  output logic [FRAC_BITS:0]   quo_o
);

  localparam int W = WORD_BITS;
  localparam int N = FRAC_BITS + 1;

  logic [W-1:0]       rem_r [N];
  logic [W-1:0]       den_r [N];
  logic [FRAC_BITS:0] quo_r [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [W-1:0]       rem_p;
    logic [W-1:0]       den_p;
    logic [FRAC_BITS:0] quo_p;
    logic               bit_in;
    logic [W:0]         rem_sh;
    logic               ge;

    if (j == 0) begin : g_first
      assign rem_p  = num_i >> 1;
      assign den_p  = den_i;
      assign quo_p  = '0;
      assign bit_in = num_i[0];
    end else begin : g_next
      assign rem_p  = rem_r[j-1];
      assign den_p  = den_r[j-1];
      assign quo_p  = quo_r[j-1];
      assign bit_in = 1'b0;
    end

    assign rem_sh = {rem_p, bit_in};
    assign ge     = rem_sh >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? W'(rem_sh - {1'b0, den_p}) : W'(rem_sh);
        den_r[j] <= den_p;
        quo_r[j] <= {quo_p[FRAC_BITS-1:0], ge};
      end
    end
  end

  assign quo_o = quo_r[N-1];

endmodule

>>> hw/rtl/vec3_alu_unit.sv
// top level of the three-component vector unit
// One beat enters per cycle while in_stall is low, and every beat gives one result
// beat through the same path whatever the opcode (Q16.16 words by default):
// three front stages (multiply, combine, saturate), WORD_BITS square-root stages
// of one root bit each, FRAC_BITS + 1 divider stages of one quotient bit each and
// an output register. While out_stall holds a waiting result the whole pipeline
// freezes and in_stall is raised; nothing is dropped or repeated.
module vec3_alu_unit #(
  parameter int WORD_BITS = v3alu_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [v3alu_pkg::OP_BITS-1:0]       in_opcode,
  input  logic signed [WORD_BITS-1:0]         in_a_x,
  input  logic signed [WORD_BITS-1:0]         in_a_y,
  input  logic signed [WORD_BITS-1:0]         in_a_z,
  input  logic signed [WORD_BITS-1:0]         in_b_x,
  input  logic signed [WORD_BITS-1:0]         in_b_y,
  input  logic signed [WORD_BITS-1:0]         in_b_z,
  input  logic signed [WORD_BITS-1:0]         in_scale_factor,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [WORD_BITS-1:0]         out_res_x,
  output logic signed [WORD_BITS-1:0]         out_res_y,
  output logic signed [WORD_BITS-1:0]         out_res_z,
  output logic signed [WORD_BITS-1:0]         out_res_scalar,
  output logic                                out_overflow
);

  localparam int W      = WORD_BITS;
  localparam int OB     = v3alu_pkg::OP_BITS;
  localparam int DV_LAT = FRAC_BITS + 1;
  localparam int DEPTH  = 3 + W + DV_LAT + 1;
  localparam int TAGW   = OB + 4 * W + 1 + 3 * W;
  localparam int SIDEW  = OB + 4 * W + 1 + 3 + 1;
  localparam int QW     = FRAC_BITS + 2;
  localparam int EW     = ((QW > W) ? QW : W) + 1;

  function automatic logic [W:0] sat_q(logic [FRAC_BITS:0] q, logic neg);
    logic signed [EW-1:0] sv;
    logic                 fits;
    sv   = neg ? -$signed(EW'(q)) : $signed(EW'(q));
    fits = (&sv[EW-1:W-1]) | ~(|sv[EW-1:W-1]);
    if (fits) begin
      sat_q = {1'b0, sv[W-1:0]};
    end else if (sv[EW-1]) begin
      sat_q = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      sat_q = {1'b1, 1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // pipeline advance and valid bits
  logic [DEPTH-1:0] vld_r;
  logic             en;

  assign en       = ~vld_r[DEPTH-1] | ~out_stall;
  assign in_stall = ~en;
  assign out_valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // front stages
  logic signed [W-1:0] a_in [3];
  logic signed [W-1:0] b_in [3];
  v3alu_pkg::op_t      fr_op;
  logic [W-1:0]        fr_res [3];
  logic [W-1:0]        fr_scal;
  logic                fr_ov;
  logic [2*W-1:0]      fr_sumsq;
  logic signed [W-1:0] fr_a [3];

  assign a_in[0] = in_a_x;
  assign a_in[1] = in_a_y;
  assign a_in[2] = in_a_z;
  assign b_in[0] = in_b_x;
  assign b_in[1] = in_b_y;
  assign b_in[2] = in_b_z;

  v3alu_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .en      (en),
    .op_i    (v3alu_pkg::op_t'(in_opcode)),
    .a_i     (a_in),
    .b_i     (b_in),
    .s_i     (in_scale_factor),
    .op_o    (fr_op),
    .res_o   (fr_res),
    .scal_o  (fr_scal),
    .ov_o    (fr_ov),
    .sumsq_o (fr_sumsq),
    .a_o     (fr_a)
  );

  // square root with the rest of the beat riding along
  logic [TAGW-1:0] sq_tag_in;
  logic [TAGW-1:0] sq_tag_out;
  logic [W-1:0]    mag;

  assign sq_tag_in = {fr_op, fr_res[0], fr_res[1], fr_res[2], fr_scal, fr_ov,
                      fr_a[0], fr_a[1], fr_a[2]};

  v3alu_sqrt #(
    .WORD_BITS (WORD_BITS),
    .TAG_BITS  (TAGW)
  ) u_sqrt (
    .clk    (clk),
    .en     (en),
    .x_i    (fr_sumsq),
    .tag_i  (sq_tag_in),
    .root_o (mag),
    .tag_o  (sq_tag_out)
  );

  logic [OB-1:0]  t_op_bits;
  v3alu_pkg::op_t t_op;
  logic [W-1:0]   t_res [3];
  logic [W-1:0]   t_scal;
  logic           t_ov;
  logic [W-1:0]   t_a [3];
  logic [W-1:0]   ua [3];
  logic [2:0]     t_neg;
  logic           mzero;
  logic [W-1:0]   m_scal;
  logic           m_ov;

  assign {t_op_bits, t_res[0], t_res[1], t_res[2], t_scal, t_ov,
          t_a[0], t_a[1], t_a[2]} = sq_tag_out;
  assign t_op  = v3alu_pkg::op_t'(t_op_bits);
  assign mzero = ~(|mag);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_neg[i] = t_a[i][W-1];
      ua[i]    = t_neg[i] ? (W'(0) - t_a[i]) : t_a[i];
    end
    m_scal = t_scal;
    m_ov   = t_ov;
    if (t_op == v3alu_pkg::OP_MAG) begin
      m_scal = mag[W-1] ? {1'b0, {(W-1){1'b1}}} : mag;
      m_ov   = mag[W-1];
    end
  end

  // normalize dividers, one per component
  logic [FRAC_BITS:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3alu_div #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .num_i (ua[i]),
      .den_i (mag),
      .quo_o (quo[i])
    );
  end

  // side delay matching the dividers
  logic [SIDEW-1:0] side_r [DV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= {t_op_bits, t_res[0], t_res[1], t_res[2], m_scal, m_ov, t_neg, mzero};
      for (int k = 1; k < DV_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  logic [OB-1:0]  d_op_bits;
  logic [W-1:0]   d_res [3];
  logic [W-1:0]   d_scal;
  logic           d_ov;
  logic [2:0]     d_neg;
  logic           d_mzero;
  logic [W:0]     nq [3];
  logic [W-1:0]   res_nxt [3];
  logic           ov_nxt;

  assign {d_op_bits, d_res[0], d_res[1], d_res[2], d_scal, d_ov, d_neg, d_mzero} =
    side_r[DV_LAT-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nq[i]      = sat_q(quo[i], d_neg[i]);
      res_nxt[i] = d_res[i];
    end
    ov_nxt = d_ov;
    if ((v3alu_pkg::op_t'(d_op_bits) == v3alu_pkg::OP_NORM) && !d_mzero) begin
      for (int i = 0; i < 3; i++) begin
        res_nxt[i] = nq[i][W-1:0];
      end
      ov_nxt = nq[0][W] | nq[1][W] | nq[2][W];
    end
  end

  // output register
  logic [W-1:0] res_x_r;
  logic [W-1:0] res_y_r;
  logic [W-1:0] res_z_r;
  logic [W-1:0] res_s_r;
  logic         ov_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res_x_r <= res_nxt[0];
      res_y_r <= res_nxt[1];
      res_z_r <= res_nxt[2];
      res_s_r <= d_scal;
      ov_r    <= ov_nxt;
    end
  end

  assign out_res_x      = res_x_r;
  assign out_res_y      = res_y_r;
  assign out_res_z      = res_z_r;
  assign out_res_scalar = res_s_r;
  assign out_overflow   = ov_r;

endmodule

>>> dv/tb_vec3_alu_unit.sv
// self-checking testbench for the three-component vector unit
module tb_vec3_alu_unit;

  localparam int W = v3alu_pkg::WORD_BITS_DEF;
  localparam int F = v3alu_pkg::FRAC_BITS_DEF;
  localparam int OB = v3alu_pkg::OP_BITS;
  localparam int LATENCY = W + F + 5;
  localparam int N_RANDOM = 650;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [OB-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [OB-1:0] op;
    logic [W-1:0] ax, ay, az, bx, by, bz, sf;
  } vec_op_t;

  typedef struct packed {
    logic [W-1:0] x, y, z, s;
    logic ov;
  } vec_res_t;

  typedef struct {
    vec_op_t op;
    logic chk;
    vec_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OB-1:0] in_opcode = '0;
  logic signed [W-1:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [W-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic signed [W-1:0] in_scale_factor = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [W-1:0] out_res_x, out_res_y, out_res_z, out_res_scalar;
  logic out_overflow;

  vec_res_t results_due[$];
  int errors = 0;
  int results_seen = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_busy = 1'b0;
  int op_count[8];

  vec3_alu_unit dut (.*);

  always #4 clk = ~clk;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE = 32'h0001_0000;

  function automatic logic [W-1:0] sat_word(input logic signed [191:0] v, inout logic ov);
    if (v > $signed({{(192-W){1'b0}}, WMAX})) begin
      ov = 1'b1;
      return WMAX;
    end
    if (v < $signed({{(192-W){1'b1}}, WMIN})) begin
      ov = 1'b1;
      return WMIN;
    end
    return v[W-1:0];
  endfunction

  function automatic logic signed [191:0] wx(input logic [W-1:0] v);
    return {{(192-W){v[W-1]}}, v};
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic vec_res_t vector_result(input vec_op_t t);
    vec_res_t r;
    logic signed [191:0] a[3], b[3], s, v, sum;
    logic [127:0] m, ua, q;
    logic ov;
    r = '0;
    ov = 1'b0;
    a[0] = wx(t.ax); a[1] = wx(t.ay); a[2] = wx(t.az);
    b[0] = wx(t.bx); b[1] = wx(t.by); b[2] = wx(t.bz);
    s = wx(t.sf);
    case (t.op)
      v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB, v3alu_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          if (t.op == v3alu_pkg::OP_ADD) v = a[i] + b[i];
          else if (t.op == v3alu_pkg::OP_SUB) v = a[i] - b[i];
          else v = (a[i] * s) >>> F;
          if (i == 0) r.x = sat_word(v, ov);
          else if (i == 1) r.y = sat_word(v, ov);
          else r.z = sat_word(v, ov);
        end
      end
      v3alu_pkg::OP_DOT: r.s = sat_word((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> F, ov);
      v3alu_pkg::OP_CROSS: begin
        r.x = sat_word((a[1]*b[2] - a[2]*b[1]) >>> F, ov);
        r.y = sat_word((a[2]*b[0] - a[0]*b[2]) >>> F, ov);
        r.z = sat_word((a[0]*b[1] - a[1]*b[0]) >>> F, ov);
      end
      v3alu_pkg::OP_MAG, v3alu_pkg::OP_NORM: begin
        sum = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        m = floor_sqrt(sum[127:0]);
        if (t.op == v3alu_pkg::OP_MAG) r.s = sat_word({64'd0, m}, ov);
        else if (m != 0) begin
          for (int i = 0; i < 3; i++) begin
            ua = a[i] < 0 ? -a[i][127:0] : a[i][127:0];
            q = (ua << F) / m;
            v = a[i] < 0 ? -$signed({64'd0, q}) : $signed({64'd0, q});
            if (i == 0) r.x = sat_word(v, ov);
            else if (i == 1) r.y = sat_word(v, ov);
            else r.z = sat_word(v, ov);
          end
        end
      end
      default: r = '0;
    endcase
    r.ov = ov;
    return r;
  endfunction

  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return WMAX;
      1: return WMIN;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4, 5: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input vec_op_t t, input logic chk, input vec_res_t want);
    vec_res_t r;
    r = vector_result(t);
    if (chk && r !== want) begin
      errors++;
      $display("%0t predictor disagrees with table row: expected %h actual %h", $time, want, r);
    end
    if (!quiet) begin
      while ($urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_opcode <= t.op;
    in_a_x <= t.ax; in_a_y <= t.ay; in_a_z <= t.az;
    in_b_x <= t.bx; in_b_y <= t.by; in_b_z <= t.bz;
    in_scale_factor <= t.sf;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results_due.push_back(r);
    op_count[t.op]++;
  endtask

  // receiver side stalls
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_busy = 1'b1;
        out_stall <= 1'b1;
        n = 0;
        while (n < 200) begin
          @(posedge clk);
          n++;
        end
        hold_req = 1'b0;
        hold_busy = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    vec_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none actual %h %h %h %h %b", $time,
                 out_res_x, out_res_y, out_res_z, out_res_scalar, out_overflow);
      end else begin
        want = results_due.pop_front();
        if (out_res_x !== want.x) begin
          errors++;
          $display("%0t res_x mismatch: expected %h actual %h", $time, want.x, out_res_x);
        end
        if (out_res_y !== want.y) begin
          errors++;
          $display("%0t res_y mismatch: expected %h actual %h", $time, want.y, out_res_y);
        end
        if (out_res_z !== want.z) begin
          errors++;
          $display("%0t res_z mismatch: expected %h actual %h", $time, want.z, out_res_z);
        end
        if (out_res_scalar !== want.s) begin
          errors++;
          $display("%0t res_scalar mismatch: expected %h actual %h", $time, want.s,
                   out_res_scalar);
        end
        if (out_overflow !== want.ov) begin
          errors++;
          $display("%0t overflow mismatch: expected %b actual %b", $time, want.ov,
                   out_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(input logic [OB-1:0] op, input logic [W-1:0] ax, ay, az,
                                   bx, by, bz, sf, input logic chk = 1'b0,
                                   input vec_res_t r = '0);
    dir_row_t d;
    d.op = '{op, ax, ay, az, bx, by, bz, sf};
    d.chk = chk;
    d.res = r;
    return d;
  endfunction

  initial begin
    vec_op_t t;
    dir_rows.push_back(row(v3alu_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0, 1'b1, '0));
    dir_rows.push_back(row(v3alu_pkg::OP_ADD, WMAX, WMIN, 1, WMAX, WMIN, 2, 0, 1'b1,
                           '{WMAX, WMIN, 32'd3, 32'd0, 1'b1}));
    dir_rows.push_back(row(v3alu_pkg::OP_SUB, WMIN, WMAX, 5, WMAX, WMIN, 2, 0, 1'b1,
                           '{WMIN, WMAX, 32'd3, 32'd0, 1'b1}));
    dir_rows.push_back(row(v3alu_pkg::OP_SCALE, ONE, WMAX, WMIN, 0, 0, 0, WMAX));
    dir_rows.push_back(row(v3alu_pkg::OP_SCALE, WMIN, WMIN, 32'hFFFF_FFFF, 0, 0, 0, WMIN));
    dir_rows.push_back(row(v3alu_pkg::OP_SCALE, 32'hFFFF_FFFF, 1, 3, 0, 0, 0, 1));
    dir_rows.push_back(row(v3alu_pkg::OP_DOT, ONE, ONE, ONE, ONE, ONE, ONE, 0, 1'b1,
                           '{32'd0, 32'd0, 32'd0, 32'h0003_0000, 1'b0}));
    dir_rows.push_back(row(v3alu_pkg::OP_DOT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 0));
    dir_rows.push_back(row(v3alu_pkg::OP_DOT, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, 0));
    dir_rows.push_back(row(v3alu_pkg::OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0, 1'b1,
                           '{32'd0, 32'd0, ONE, 32'd0, 1'b0}));
    dir_rows.push_back(row(v3alu_pkg::OP_CROSS, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0));
    dir_rows.push_back(row(v3alu_pkg::OP_CROSS, 32'hFFFF_FFFF, 1, 0, 1, 1, 0, 0));
    dir_rows.push_back(row(v3alu_pkg::OP_MAG, 0, 0, 0, 0, 0, 0, 0, 1'b1, '0));
    dir_rows.push_back(row(v3alu_pkg::OP_MAG, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0,
                           1'b1, '{32'd0, 32'd0, 32'd0, 32'h0005_0000, 1'b0}));
    dir_rows.push_back(row(v3alu_pkg::OP_MAG, WMIN, WMIN, WMIN, 0, 0, 0, 0));
    dir_rows.push_back(row(v3alu_pkg::OP_MAG, WMAX, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(v3alu_pkg::OP_NORM, 0, 0, 0, WMAX, WMIN, 1, WMAX, 1'b1, '0));
    dir_rows.push_back(row(v3alu_pkg::OP_NORM, 32'h0002_0000, 0, 0, 0, 0, 0, 0, 1'b1,
                           '{ONE, 32'd0, 32'd0, 32'd0, 1'b0}));
    dir_rows.push_back(row(v3alu_pkg::OP_NORM, 0, 32'hFFFD_0000, 0, 0, 0, 0, 0, 1'b1,
                           '{32'd0, 32'hFFFF_0000, 32'd0, 32'd0, 1'b0}));
    dir_rows.push_back(row(v3alu_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(v3alu_pkg::OP_NORM, WMIN, WMAX, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(OP_UNUSED, WMAX, WMIN, 1, WMAX, WMIN, 1, WMAX, 1'b1, '0));
    dir_rows.push_back(row(v3alu_pkg::OP_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                           32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].op, dir_rows[i].chk, dir_rows[i].res);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 150) hold_req = 1'b1;
      if (k == N_RANDOM - 80) quiet = 1'b1;
      t.op = ($urandom_range(0, 30) == 0) ? OP_UNUSED : OB'($urandom_range(0, 6));
      t.ax = rand_word(); t.ay = rand_word(); t.az = rand_word();
      t.bx = rand_word(); t.by = rand_word(); t.bz = rand_word();
      t.sf = rand_word();
      send_beat(t, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (results_due.size() != 0 || hold_busy) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("%0d beats checked: add %0d sub %0d scale %0d dot %0d cross %0d", results_seen,
             op_count[v3alu_pkg::OP_ADD], op_count[v3alu_pkg::OP_SUB],
             op_count[v3alu_pkg::OP_SCALE], op_count[v3alu_pkg::OP_DOT],
             op_count[v3alu_pkg::OP_CROSS]);
    $display("magnitude %0d normalize %0d unused opcode %0d, with saturation and stalls",
             op_count[v3alu_pkg::OP_MAG], op_count[v3alu_pkg::OP_NORM],
             op_count[OP_UNUSED]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
